### rtl/date_add_days_defines.svh
// Assertion macros shared by the date adder RTL.
// Requires clk_i and rst_ni in the scope of each use.
`ifndef DATE_ADD_DAYS_DEFINES_SVH
`define DATE_ADD_DAYS_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DAD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("date_add_days: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define DAD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("date_add_days: next-cycle check failed");

`endif

### rtl/dad_pkg.sv
// Package for the date adder: word types, microcode format, program ROM
// and calendar tables. Used by date_add_days; depends on nothing.
package dad_pkg;

  localparam int unsigned DaysWidth = 20;
  localparam int unsigned AccWidth  = (DaysWidth > 21) ? DaysWidth + 2 : 23;
  localparam int unsigned PcWidth   = 4;
  localparam int unsigned CntWidth  = 5;

  localparam logic [AccWidth-1:0] OverflowSerial = AccWidth'(3652059);
  localparam logic [13:0]         MaxYear        = 14'd9999;
  localparam logic [3:0]          LastMonth      = 4'd12;
  localparam logic [3:0]          FirstMonth     = 4'd1;
  localparam logic [3:0]          February       = 4'd2;
  localparam logic [4:0]          LastDay        = 5'd31;

  typedef struct packed {
    logic [4:0]           start_day;
    logic [3:0]           start_month;
    logic [13:0]          start_year;
    logic [DaysWidth-1:0] days_to_add;
  } in_word_t;

  typedef struct packed {
    logic [4:0]  end_day;
    logic [3:0]  end_month;
    logic [13:0] end_year;
    logic        year_overflow;
  } out_word_t;

  localparam logic [2:0] OpEnc     = 3'd0;
  localparam logic [2:0] OpDec     = 3'd1;
  localparam logic [2:0] OpAddDate = 3'd2;
  localparam logic [2:0] OpAddDays = 3'd3;
  localparam logic [2:0] OpOvf     = 3'd4;
  localparam logic [2:0] OpClr     = 3'd5;
  localparam logic [2:0] OpMon     = 3'd6;
  localparam logic [2:0] OpDone    = 3'd7;

  localparam logic [1:0] FlagNone = 2'd0;
  localparam logic [1:0] FlagCent = 2'd1;
  localparam logic [1:0] FlagQuad = 2'd2;
  localparam logic [1:0] FlagYear = 2'd3;

  localparam logic [PcWidth-1:0] PcDone = 4'd13;
  localparam logic [PcWidth-1:0] PcLast = 4'd13;

  typedef struct packed {
    logic [2:0]          op;
    logic [8:0]          step;
    logic [17:0]         blk;
    logic [1:0]          lim;
    logic [1:0]          fsel;
    logic [CntWidth-1:0] fcmp;
    logic [PcWidth-1:0]  jmp;
  } ucode_t;

  // Encode loops turn year-1 into days by 400/100/4/1-year blocks; decode
  // loops undo it. The loop counts decide the leap flags.
  function automatic ucode_t ucode_rom(input logic [PcWidth-1:0] pc);
    ucode_t uc;
    uc = '{op: OpDone, step: 9'd0, blk: 18'd0, lim: 2'd0, fsel: FlagNone,
           fcmp: 5'd0, jmp: 4'd0};
    case (pc)
      4'd0: begin
        uc.op = OpEnc; uc.step = 9'd400; uc.blk = 18'd146097;
      end
      4'd1: begin
        uc.op = OpEnc; uc.step = 9'd100; uc.blk = 18'd36524;
        uc.fsel = FlagCent; uc.fcmp = 5'd3;
      end
      4'd2: begin
        uc.op = OpEnc; uc.step = 9'd4; uc.blk = 18'd1461;
        uc.fsel = FlagQuad; uc.fcmp = 5'd24;
      end
      4'd3: begin
        uc.op = OpEnc; uc.step = 9'd1; uc.blk = 18'd365;
        uc.fsel = FlagYear; uc.fcmp = 5'd3;
      end
      4'd4: uc.op = OpAddDate;
      4'd5: uc.op = OpAddDays;
      4'd6: begin
        uc.op = OpOvf; uc.jmp = PcDone;
      end
      4'd7: uc.op = OpClr;
      4'd8: begin
        uc.op = OpDec; uc.step = 9'd400; uc.blk = 18'd146097;
      end
      4'd9: begin
        uc.op = OpDec; uc.step = 9'd100; uc.blk = 18'd36524; uc.lim = 2'd3;
        uc.fsel = FlagCent; uc.fcmp = 5'd3;
      end
      4'd10: begin
        uc.op = OpDec; uc.step = 9'd4; uc.blk = 18'd1461;
        uc.fsel = FlagQuad; uc.fcmp = 5'd24;
      end
      4'd11: begin
        uc.op = OpDec; uc.step = 9'd1; uc.blk = 18'd365; uc.lim = 2'd3;
        uc.fsel = FlagYear; uc.fcmp = 5'd3;
      end
      4'd12: uc.op = OpMon;
      default: uc.op = OpDone;
    endcase
    return uc;
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before_month(input logic [3:0] mon);
    logic [8:0] d;
    case (mon)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

### rtl/date_add_days.sv
// Time per word is set by the iterations of the 400/100/4/1-year loops
// (encode and decode), the month loop of the sequencer and output stalls.
// Throughput: one word at a time; the next input word is taken in the cycle
// after the result moves into the output register.
// Reset clears the sequencer, the busy flag and the output valid flag.
// Top level of the date adder; uses dad_pkg and date_add_days_defines.svh.
`include "date_add_days_defines.svh"

module date_add_days (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  dad_pkg::in_word_t    in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output dad_pkg::out_word_t   out_word_o
);

  logic                              busy_q, busy_d;
  logic [dad_pkg::PcWidth-1:0]       pc_q, pc_d;
  logic [dad_pkg::AccWidth-1:0]      acc_q, acc_d;
  logic [13:0]                       yr_q, yr_d;
  logic [3:0]                        mon_q, mon_d;
  logic [4:0]                        day_q, day_d;
  logic [dad_pkg::DaysWidth-1:0]     add_q, add_d;
  logic [dad_pkg::CntWidth-1:0]      cnt_q, cnt_d;
  logic [2:0]                        flg_q, flg_d;
  logic                              ovf_q, ovf_d;
  logic                              out_valid_q, out_valid_d;
  dad_pkg::out_word_t                out_word_q, out_word_d;

  dad_pkg::ucode_t uc;
  logic            leap;
  logic            enc_go;
  logic            dec_go;
  logic            mon_go;
  logic [4:0]      mon_len;
  logic            accept;
  logic            out_free;

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign accept      = in_valid_i && !busy_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    uc      = dad_pkg::ucode_rom(pc_q);
    leap    = flg_q[2] && (!flg_q[1] || flg_q[0]);
    mon_len = dad_pkg::month_days(mon_q, leap);
    enc_go  = yr_q >= 14'(uc.step);
    dec_go  = (acc_q >= dad_pkg::AccWidth'(uc.blk))
              && ((uc.lim == 2'd0) || (cnt_q != dad_pkg::CntWidth'(uc.lim)));
    mon_go  = (mon_q < dad_pkg::LastMonth) && (acc_q >= dad_pkg::AccWidth'(mon_len));
  end

  always_comb begin
    busy_d      = busy_q;
    pc_d        = pc_q;
    acc_d       = acc_q;
    yr_d        = yr_q;
    mon_d       = mon_q;
    day_d       = day_q;
    add_d       = add_q;
    cnt_d       = cnt_q;
    flg_d       = flg_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (accept) begin
      busy_d = 1'b1;
      pc_d   = '0;
      acc_d  = '0;
      cnt_d  = '0;
      ovf_d  = 1'b0;
      add_d  = in_word_i.days_to_add;
      day_d  = (in_word_i.start_day == 5'd0) ? 5'd1 : in_word_i.start_day;
      yr_d   = (in_word_i.start_year == 14'd0) ? 14'd0 : in_word_i.start_year - 14'd1;
      if (in_word_i.start_month == 4'd0) begin
        mon_d = dad_pkg::FirstMonth;
      end else if (in_word_i.start_month > dad_pkg::LastMonth) begin
        mon_d = dad_pkg::LastMonth;
      end else begin
        mon_d = in_word_i.start_month;
      end
    end else if (busy_q) begin
      case (uc.op)
        dad_pkg::OpEnc, dad_pkg::OpDec: begin
          if ((uc.op == dad_pkg::OpEnc) ? enc_go : dec_go) begin
            cnt_d = cnt_q + 5'd1;
            if (uc.op == dad_pkg::OpEnc) begin
              yr_d  = yr_q - 14'(uc.step);
              acc_d = acc_q + dad_pkg::AccWidth'(uc.blk);
            end else begin
              yr_d  = yr_q + 14'(uc.step);
              acc_d = acc_q - dad_pkg::AccWidth'(uc.blk);
            end
          end else begin
            cnt_d = '0;
            pc_d  = pc_q + 4'd1;
            case (uc.fsel)
              dad_pkg::FlagCent: flg_d[0] = (cnt_q == uc.fcmp);
              dad_pkg::FlagQuad: flg_d[1] = (cnt_q == uc.fcmp);
              dad_pkg::FlagYear: flg_d[2] = (cnt_q == uc.fcmp);
              default: flg_d = flg_q;
            endcase
          end
        end
        dad_pkg::OpAddDate: begin
          acc_d = acc_q
                  + dad_pkg::AccWidth'(dad_pkg::days_before_month(mon_q))
                  + dad_pkg::AccWidth'(day_q - 5'd1)
                  + dad_pkg::AccWidth'((mon_q > dad_pkg::February) && leap);
          pc_d  = pc_q + 4'd1;
        end
        dad_pkg::OpAddDays: begin
          acc_d = acc_q + dad_pkg::AccWidth'(add_q);
          pc_d  = pc_q + 4'd1;
        end
        dad_pkg::OpOvf: begin
          if (acc_q >= dad_pkg::OverflowSerial) begin
            ovf_d = 1'b1;
            pc_d  = uc.jmp;
          end else begin
            pc_d = pc_q + 4'd1;
          end
        end
        dad_pkg::OpClr: begin
          yr_d  = '0;
          mon_d = dad_pkg::FirstMonth;
          cnt_d = '0;
          pc_d  = pc_q + 4'd1;
        end
        dad_pkg::OpMon: begin
          if (mon_go) begin
            acc_d = acc_q - dad_pkg::AccWidth'(mon_len);
            mon_d = mon_q + 4'd1;
          end else begin
            pc_d = pc_q + 4'd1;
          end
        end
        dad_pkg::OpDone: begin
          if (out_free) begin
            busy_d      = 1'b0;
            out_valid_d = 1'b1;
            if (ovf_q) begin
              out_word_d.end_day       = dad_pkg::LastDay;
              out_word_d.end_month     = dad_pkg::LastMonth;
              out_word_d.end_year      = dad_pkg::MaxYear;
              out_word_d.year_overflow = 1'b1;
            end else begin
              out_word_d.end_day       = acc_q[4:0] + 5'd1;
              out_word_d.end_month     = mon_q;
              out_word_d.end_year      = yr_q + 14'd1;
              out_word_d.year_overflow = 1'b0;
            end
          end
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= '0;
      cnt_q       <= '0;
      flg_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      cnt_q       <= cnt_d;
      flg_q       <= flg_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    yr_q       <= yr_d;
    mon_q      <= mon_d;
    day_q      <= day_d;
    add_q      <= add_d;
    out_word_q <= out_word_d;
  end

  `DAD_ASSERT_IMP(a_pc_in_program, busy_q, pc_q <= dad_pkg::PcLast)
  `DAD_ASSERT_NXT(a_accept_starts, in_valid_i && !in_stall_o, busy_q && (pc_q == '0))
  `DAD_ASSERT_IMP(a_ovf_saturates, out_valid_o && out_word_o.year_overflow,
                  (out_word_o.end_year == dad_pkg::MaxYear)
                  && (out_word_o.end_month == dad_pkg::LastMonth)
                  && (out_word_o.end_day == dad_pkg::LastDay))
  `DAD_ASSERT_IMP(a_result_range, out_valid_o && !out_word_o.year_overflow,
                  (out_word_o.end_year <= dad_pkg::MaxYear)
                  && (out_word_o.end_month != 4'd0)
                  && (out_word_o.end_month <= dad_pkg::LastMonth)
                  && (out_word_o.end_day != 5'd0))

endmodule

### tb/tb_date_add_days.sv
// Self-checking testbench for date_add_days: drives start dates and day counts,
// predicts the advanced date from its own calendar arithmetic and checks each word.
// Depends on dad_pkg and the date_add_days RTL.
`timescale 1ns / 1ps

module tb_date_add_days;
  import dad_pkg::*;

  localparam int unsigned DaysPer400Years = 146097;
  localparam int unsigned DaysPer100Years = 36524;
  localparam int unsigned DaysPer4Years   = 1461;
  localparam int unsigned DaysPerYear     = 365;
  localparam int unsigned DaysCountMax    = (1 << DaysWidth) - 1;
  localparam int unsigned MonthLen [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int unsigned DaysBefore [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                              304, 334};

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_word_o;

  out_word_t pending_dates [$];
  int        mismatch_count;
  int        hold_request;
  bit        sender_quiet;
  bit        receiver_quiet;

  date_add_days dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic bit leap_year(input longint unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic longint unsigned days_to_new_year(input longint unsigned y);
    longint unsigned p;
    p = y - 1;
    return p * DaysPerYear + p / 4 - p / 100 + p / 400;
  endfunction

  function automatic int unsigned month_length(input int unsigned m, input longint unsigned y);
    int unsigned len;
    len = MonthLen[m - 1];
    if (m == February && leap_year(y)) len = len + 1;
    return len;
  endfunction

  function automatic out_word_t predict_date(input in_word_t w);
    out_word_t       r;
    longint unsigned day, yr, serial, rem, n;
    int unsigned     mon;
    day = w.start_day;
    mon = w.start_month;
    yr  = w.start_year;
    if (day == 0) day = 1;
    if (mon == 0) mon = FirstMonth;
    if (mon > LastMonth) mon = LastMonth;
    if (yr == 0) yr = 1;
    serial = days_to_new_year(yr) + DaysBefore[mon - 1] + day - 1;
    if (mon > February && leap_year(yr)) serial = serial + 1;
    serial = serial + w.days_to_add;
    if (serial >= days_to_new_year(MaxYear + 1)) begin
      r.end_day       = LastDay;
      r.end_month     = LastMonth;
      r.end_year      = MaxYear;
      r.year_overflow = 1'b1;
      return r;
    end
    yr  = 400 * (serial / DaysPer400Years);
    rem = serial % DaysPer400Years;
    n = rem / DaysPer100Years;
    if (n > 3) n = 3;
    rem = rem - n * DaysPer100Years;
    yr  = yr + 100 * n;
    n = rem / DaysPer4Years;
    rem = rem - n * DaysPer4Years;
    yr  = yr + 4 * n;
    n = rem / DaysPerYear;
    if (n > 3) n = 3;
    rem = rem - n * DaysPerYear;
    yr  = yr + n + 1;
    mon = FirstMonth;
    while (mon < LastMonth && rem >= month_length(mon, yr)) begin
      rem = rem - month_length(mon, yr);
      mon = mon + 1;
    end
    r.end_day       = 5'(rem + 1);
    r.end_month     = 4'(mon);
    r.end_year      = 14'(yr);
    r.year_overflow = 1'b0;
    return r;
  endfunction

  function automatic in_word_t make_date(input int unsigned d, input int unsigned m,
                                         input int unsigned y, input int unsigned add);
    in_word_t w;
    w.start_day   = 5'(d);
    w.start_month = 4'(m);
    w.start_year  = 14'(y);
    w.days_to_add = DaysWidth'(add);
    return w;
  endfunction

  function automatic in_word_t random_date();
    in_word_t    w;
    int unsigned pick, m, y, add;
    pick = $urandom_range(99);
    if (pick < 12) begin
      return make_date($urandom_range(31), $urandom_range(15), $urandom_range(16383),
                       $urandom_range(DaysCountMax));
    end
    m = $urandom_range(12, 1);
    y = (pick < 20) ? $urandom_range(MaxYear, 9900) : $urandom_range(MaxYear, 1);
    case ($urandom_range(3))
      0:       add = $urandom_range(60);
      1:       add = $urandom_range(800);
      2:       add = $urandom_range(50000);
      default: add = $urandom_range(DaysCountMax);
    endcase
    return make_date($urandom_range(month_length(m, y), 1), m, y, add);
  endfunction

  task automatic send_date(input in_word_t w);
    while (!sender_quiet && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    pending_dates.push_back(predict_date(w));
  endtask

  task automatic wait_drained();
    while (pending_dates.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int hold_left;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_dates.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected word: %0d/%0d/%0d ovf %0d", out_word_o.end_day,
                     out_word_o.end_month, out_word_o.end_year, out_word_o.year_overflow);
        end else begin
          out_word_t want;
          want = pending_dates.pop_front();
          if (out_word_o !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected %0d/%0d/%0d ovf %0d, got %0d/%0d/%0d ovf %0d",
                       want.end_day, want.end_month, want.end_year, want.year_overflow,
                       out_word_o.end_day, out_word_o.end_month, out_word_o.end_year,
                       out_word_o.year_overflow);
          end
        end
      end
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= !receiver_quiet && ($urandom_range(99) < 7);
      end
    end
  end

  task automatic test_field_extremes();
    send_date(make_date(1, 1, 1, 0));
    send_date(make_date(31, 12, MaxYear, 0));
    send_date(make_date(31, 12, MaxYear, 1));
    send_date(make_date(31, 12, 9998, 1));
    send_date(make_date(1, 1, 1, DaysCountMax));
    send_date(make_date(1, 1, 8000, DaysCountMax));
    send_date(make_date(30, 11, 2023, 31));
  endtask

  task automatic test_leap_rules();
    send_date(make_date(28, 2, 2000, 1));
    send_date(make_date(28, 2, 1900, 1));
    send_date(make_date(28, 2, 2004, 1));
    send_date(make_date(29, 2, 2000, 365));
    send_date(make_date(31, 12, 2000, 1));
    send_date(make_date(1, 3, 2100, 36524));
  endtask

  // Out-of-range dates: zero day, day past month end, bad months, zero and huge years.
  task automatic test_odd_inputs();
    send_date(make_date(0, 5, 1999, 0));
    send_date(make_date(31, 2, 2001, 0));
    send_date(make_date(31, 4, 2000, 10));
    send_date(make_date(15, 0, 1500, 3));
    send_date(make_date(15, 15, 1500, 3));
    send_date(make_date(7, 6, 0, 100));
    send_date(make_date(1, 1, 10000, 0));
    send_date(make_date(31, 15, 16383, DaysCountMax));
  endtask

  task automatic test_random_dates(input int count);
    for (int i = 0; i < count; i++) send_date(random_date());
  endtask

  // The receiver holds off long enough that the block fills up and stalls its input.
  task automatic test_backpressure();
    hold_request = 400;
    sender_quiet = 1'b1;
    for (int i = 0; i < 12; i++) send_date(random_date());
    sender_quiet = 1'b0;
    in_valid_i <= 1'b0;
    wait_drained();
  endtask

  task automatic test_quiet_run(input int count);
    sender_quiet   = 1'b1;
    receiver_quiet = 1'b1;
    for (int i = 0; i < count; i++) send_date(random_date());
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
  endtask

  initial begin
    mismatch_count = 0;
    hold_request   = 0;
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
    in_valid_i     = 1'b0;
    in_word_i      = '0;
    rst_ni         = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_field_extremes();
    test_leap_rules();
    test_odd_inputs();
    test_random_dates(80);
    test_backpressure();
    test_quiet_run(30);
    test_random_dates(80);
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0 && pending_dates.size() == 0) begin
      $display("tb_date_add_days: done, clean");
    end else begin
      $display("tb_date_add_days: done, errors");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("tb_date_add_days: done, errors");
    $finish;
  end

endmodule
